### rtl/core/char_lcd_nibble_sequencer_core_assert.svh
// Assertion macros shared by the LCD nibble sequencer modules.
// Each user module must provide clk_i and rst_ni.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH

// Checked only while out of reset.
`define CLNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define CLNS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/clns_pkg.sv
// Types, codes and constant tables for the LCD nibble sequencer.
// No dependencies.
package clns_pkg;

  localparam int unsigned HoldW     = 17;
  localparam int unsigned FifoDepth = 4;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  localparam logic [0:0] CFG_LINE_LENGTH = 1'b0;
  localparam logic [0:0] CFG_CHAR_WAIT   = 1'b1;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
  localparam logic [7:0] CMD_LINE_ONE  = 8'h80;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_LINE_TWO  = 8'hC0;

  localparam logic [HoldW-1:0] WAIT_POWER_UP = 17'd70000;
  localparam logic [HoldW-1:0] WAIT_LONG     = 17'd20000;
  localparam logic [HoldW-1:0] WAIT_SHORT    = 17'd700;
  localparam logic [HoldW-1:0] WAIT_WRAP     = 17'd400;
  localparam logic [HoldW-1:0] WAIT_STRING   = 17'd100000;
  localparam logic [HoldW-1:0] HOLD_EN_HIGH  = 17'd5;
  localparam logic [HoldW-1:0] HOLD_EN_LOW   = 17'd2;
  localparam logic [HoldW-1:0] HOLD_CLEARED  = 17'd30;

  localparam logic [5:0] LINE_NO_WRAP  = 6'd63;
  localparam logic [5:0] RESET_LINE    = 6'd16;
  localparam logic [15:0] RESET_CHAR_W = 16'd500;

  localparam logic [2:0] PHASE_FIRST = 3'd0;
  localparam logic [2:0] PHASE_FOLD  = 3'd5;
  localparam logic [2:0] PHASE_WAIT  = 3'd6;

  // One byte transfer (or the idle pause) for the back end.
  typedef struct packed {
    logic             rs;
    logic [7:0]       byte_val;
    logic [HoldW-1:0] wait_len;
    logic             fold;
    logic             idle;
    logic             last;
  } job_t;

  typedef struct packed {
    logic             rs;
    logic             en;
    logic [3:0]       nibble;
    logic [HoldW-1:0] hold;
    logic             last;
  } phase_t;

  function automatic logic [7:0] init_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0, 4'd1, 4'd2: b = CMD_FUNC_SET;
      4'd3:             b = CMD_DISP_OFF;
      4'd4:             b = CMD_CLEAR;
      4'd5:             b = CMD_ENTRY;
      4'd6:             b = CMD_DISP_ON;
      4'd7:             b = CMD_LINE_ONE;
      default:          b = CMD_HOME;
    endcase
    return b;
  endfunction

  function automatic logic [HoldW-1:0] init_wait(input logic [3:0] idx);
    logic [HoldW-1:0] w;
    case (idx)
      4'd0, 4'd1, 4'd2: w = WAIT_POWER_UP;
      4'd3, 4'd5, 4'd7: w = WAIT_SHORT;
      default:          w = WAIT_LONG;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] last_step(input logic [1:0] kind);
    logic [3:0] s;
    case (kind)
      KIND_CMD:   s = 4'd0;
      KIND_CHAR:  s = 4'd1;
      KIND_INIT:  s = 4'd8;
      KIND_START: s = 4'd3;
      default:    s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/clns_front.sv
// Front end: accepts request words, keeps the column count and the
// configuration, and breaks each request into byte jobs. Uses clns_pkg.
module clns_front import clns_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_kind_i,
  input  logic [7:0]  in_byte_i,
  input  logic [HoldW-1:0] in_wait_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  logic [5:0]       line_len_q;
  logic [15:0]      char_wait_q;
  logic [5:0]       col_q, col_d;
  logic             busy_q, busy_d;
  logic [3:0]       step_q, step_d;
  logic [1:0]       kind_q;
  logic [7:0]       byte_q;
  logic [HoldW-1:0] wait_q;
  logic             accept, wrap, done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q  <= RESET_LINE;
      char_wait_q <= RESET_CHAR_W;
    end else if (cfg_we_i && cfg_idx_i[1] == 1'b0) begin
      if (cfg_idx_i[0] == CFG_LINE_LENGTH) begin
        line_len_q <= cfg_data_i[5:0];
      end else begin
        char_wait_q <= cfg_data_i;
      end
    end
  end

  assign push_o     = busy_q && !full_i;
  assign done       = push_o && (step_q == last_step(kind_q));
  assign in_ready_o = !busy_q || done;
  assign accept     = in_valid_i && in_ready_o;
  assign wrap       = (col_q == line_len_q) && (line_len_q != LINE_NO_WRAP);

  always_comb begin
    col_d  = col_q;
    busy_d = busy_q;
    step_d = step_q;
    if (push_o) begin
      step_d = step_q + 4'd1;
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      step_d = 4'd0;
      if (in_kind_i == KIND_CHAR) begin
        step_d = wrap ? 4'd0 : 4'd1;
        if (col_q != LINE_NO_WRAP) begin
          col_d = col_q + 6'd1;
        end
      end else if (in_kind_i == KIND_START) begin
        col_d = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 6'd0;
      busy_q <= 1'b0;
      step_q <= 4'd0;
    end else begin
      col_q  <= col_d;
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind_i;
      byte_q <= in_byte_i;
      wait_q <= in_wait_i;
    end
  end

  always_comb begin
    job_o          = '0;
    job_o.last     = (step_q == last_step(kind_q));
    case (kind_q)
      KIND_CMD: begin
        job_o.byte_val = byte_q;
        job_o.wait_len = wait_q;
      end
      KIND_CHAR: begin
        if (step_q == 4'd0) begin
          job_o.byte_val = CMD_LINE_TWO;
          job_o.wait_len = WAIT_WRAP;
        end else begin
          job_o.rs       = 1'b1;
          job_o.byte_val = byte_q;
          job_o.wait_len = {1'b0, char_wait_q};
        end
      end
      KIND_INIT: begin
        job_o.byte_val = init_byte(step_q);
        job_o.wait_len = init_wait(step_q);
        job_o.fold     = 1'b1;
      end
      KIND_START: begin
        case (step_q)
          4'd0: begin
            job_o.byte_val = CMD_CLEAR;
            job_o.wait_len = WAIT_LONG;
          end
          4'd1: begin
            job_o.byte_val = CMD_LINE_ONE;
            job_o.wait_len = WAIT_SHORT;
          end
          4'd2: begin
            job_o.byte_val = CMD_HOME;
            job_o.wait_len = WAIT_LONG;
          end
          default: begin
            job_o.wait_len = WAIT_STRING;
            job_o.idle     = 1'b1;
          end
        endcase
      end
      default: job_o = '0;
    endcase
  end

`include "char_lcd_nibble_sequencer_core_assert.svh"

  `CLNS_ASSERT(a_step_in_range, busy_q |-> (step_q <= last_step(kind_q)), "front step overran its request")

endmodule

### rtl/core/clns_fifo.sv
// Short job queue between the front and back ends.
// Uses clns_pkg for the job type.
module clns_fifo import clns_pkg::*; #(
  parameter int unsigned DEPTH = FifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`include "char_lcd_nibble_sequencer_core_assert.svh"

  `CLNS_ASSERT(a_no_overflow, !(push_i && full_o), "push into a full job queue")
  `CLNS_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from an empty job queue")

endmodule

### rtl/core/clns_back.sv
// Back end: expands each byte job into pin phases, one per cycle unless
// out_ready_i stalls, into a registered output word. Uses clns_pkg.
module clns_back import clns_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  job_t   job_i,
  input  logic   empty_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output phase_t out_o
);

  job_t   job_q;
  logic   job_valid_q, job_valid_d;
  logic [2:0] phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  phase_t out_q, out_d;
  logic   adv, final_ph;

  assign adv      = job_valid_q && (!out_valid_q || out_ready_i);
  assign final_ph = job_q.fold ? (phase_q == PHASE_FOLD) : (phase_q == PHASE_WAIT);
  assign pop_o    = !empty_i && (!job_valid_q || (adv && final_ph));

  always_comb begin
    out_d      = '0;
    out_d.rs   = job_q.rs;
    out_d.last = job_q.last && final_ph;
    case (phase_q)
      3'd0: begin
        out_d.en     = 1'b1;
        out_d.nibble = job_q.byte_val[7:4];
        out_d.hold   = HOLD_EN_HIGH;
      end
      3'd1: begin
        out_d.nibble = job_q.byte_val[7:4];
        out_d.hold   = HOLD_EN_LOW;
      end
      3'd2: out_d.hold = HOLD_CLEARED;
      3'd3: begin
        out_d.en     = 1'b1;
        out_d.nibble = job_q.byte_val[3:0];
        out_d.hold   = HOLD_EN_HIGH;
      end
      3'd4: begin
        out_d.nibble = job_q.byte_val[3:0];
        out_d.hold   = HOLD_EN_LOW;
      end
      3'd5: begin
        out_d.rs   = 1'b0;
        out_d.hold = job_q.fold ? HOLD_CLEARED + job_q.wait_len : HOLD_CLEARED;
      end
      default: begin
        out_d.rs   = 1'b0;
        out_d.hold = job_q.wait_len;
      end
    endcase
  end

  always_comb begin
    job_valid_d = job_valid_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      phase_d     = phase_q + 3'd1;
      if (final_ph) begin
        job_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      job_valid_d = 1'b1;
      phase_d     = job_i.idle ? PHASE_WAIT : PHASE_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      phase_q     <= PHASE_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "char_lcd_nibble_sequencer_core_assert.svh"

  `CLNS_ASSERT(a_phase_in_range, job_valid_q |-> (phase_q <= PHASE_WAIT && !(job_q.fold && phase_q == PHASE_WAIT)), "phase counter ran past the end of its job")

endmodule

### rtl/core/char_lcd_nibble_sequencer_core.sv
// Channel  | dir | tdata (low bit up)                  | tuser      | tlast
// s_axis   | in  | byte_value[7:0], wait_after[24:8]   | kind[1:0]  | -
// m_axis   | out | enable[0], data_nibble[4:1],        | reg_select | last
//          |     | hold_time[21:5]                     |            |
// One pin phase leaves per cycle while jobs wait and m_axis_tready is high,
// paced by the back end's phase counter; a wrap puts a line-two job first.
// The front end takes a new word while the back end still drains earlier jobs.
// A low m_axis_tready freezes the output word; the front keeps going until
// the job queue fills. Reset restores the register defaults and a zero column.
// Top level of the LCD nibble sequencer; uses clns_pkg, clns_front,
// clns_fifo and clns_back.
module char_lcd_nibble_sequencer_core import clns_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // byte_value, wait_after, zero pad
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // enable, data_nibble, hold_time, zero pad
  output logic        m_axis_tuser,  // reg_select
  output logic        m_axis_tlast
);

  logic   push, full, pop, empty;
  job_t   push_job, pop_job;
  phase_t ph;

  clns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata[7:0]),
    .in_wait_i  (s_axis_tdata[24:8]),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  clns_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (ph)
  );

  assign m_axis_tdata = {2'b00, ph.hold, ph.nibble, ph.en};
  assign m_axis_tuser = ph.rs;
  assign m_axis_tlast = ph.last;

endmodule
